[hw/rtl/irn_pkg.sv]
`timescale 1ns / 1ps

package irn_pkg;

  // Field widths
  localparam int ValueW  = 12;
  localparam int SymbolW = 7;
  localparam int InDataW  = 16;
  localparam int OutDataW = 8;

  // Saturation limit of the input value
  localparam logic [ValueW-1:0] VALUE_MAX = 12'd3999;

  // Scaled compare values reach 9 * 1000, so they need 14 bits
  localparam int ScaleW = 14;

  // Microprogram address width (13 control words)
  localparam int UaddrW = 4;

  // ASCII letters
  localparam logic [SymbolW-1:0] CH_C = 7'd67;
  localparam logic [SymbolW-1:0] CH_D = 7'd68;
  localparam logic [SymbolW-1:0] CH_I = 7'd73;
  localparam logic [SymbolW-1:0] CH_L = 7'd76;
  localparam logic [SymbolW-1:0] CH_M = 7'd77;
  localparam logic [SymbolW-1:0] CH_V = 7'd86;
  localparam logic [SymbolW-1:0] CH_X = 7'd88;

  // Decimal places
  localparam logic [1:0] PLACE_UNITS    = 2'd0;
  localparam logic [1:0] PLACE_TENS     = 2'd1;
  localparam logic [1:0] PLACE_HUNDREDS = 2'd2;
  localparam logic [1:0] PLACE_THOUS    = 2'd3;

  // Micro-operations
  typedef enum logic [1:0] {
    OP_WAIT,
    OP_SPLIT,
    OP_EMIT
  } irn_op_t;

  // Letter of the current place to emit
  typedef enum logic [1:0] {
    SEL_ONE,
    SEL_FIVE,
    SEL_TEN
  } irn_sel_t;

  // One control word
  typedef struct packed {
    irn_op_t           op;
    irn_sel_t          sel;
    logic              fin;   // digit routine ends after this word
    logic [UaddrW-1:0] nxt;
  } irn_uword_t;

  // Microprogram addresses
  localparam logic [UaddrW-1:0] UA_WAIT  = 4'd0;
  localparam logic [UaddrW-1:0] UA_SPLIT = 4'd1;
  localparam logic [UaddrW-1:0] UA_ONE3  = 4'd2;
  localparam logic [UaddrW-1:0] UA_ONE2  = 4'd3;
  localparam logic [UaddrW-1:0] UA_ONE1  = 4'd4;
  localparam logic [UaddrW-1:0] UA_FOUR  = 4'd5;
  localparam logic [UaddrW-1:0] UA_FOUR2 = 4'd6;
  localparam logic [UaddrW-1:0] UA_FIVE  = 4'd7;
  localparam logic [UaddrW-1:0] UA_SIX   = 4'd8;
  localparam logic [UaddrW-1:0] UA_SEVEN = 4'd9;
  localparam logic [UaddrW-1:0] UA_EIGHT = 4'd10;
  localparam logic [UaddrW-1:0] UA_NINE  = 4'd11;
  localparam logic [UaddrW-1:0] UA_NINE2 = 4'd12;

  // Control store
  function automatic irn_uword_t ucode(input logic [UaddrW-1:0] addr);
    irn_uword_t w;
    w = '{op: OP_WAIT, sel: SEL_ONE, fin: 1'b0, nxt: UA_SPLIT};
    case (addr)
      UA_WAIT:  w = '{op: OP_WAIT,  sel: SEL_ONE,  fin: 1'b0, nxt: UA_SPLIT};
      UA_SPLIT: w = '{op: OP_SPLIT, sel: SEL_ONE,  fin: 1'b0, nxt: UA_WAIT};
      UA_ONE3:  w = '{op: OP_EMIT,  sel: SEL_ONE,  fin: 1'b0, nxt: UA_ONE2};
      UA_ONE2:  w = '{op: OP_EMIT,  sel: SEL_ONE,  fin: 1'b0, nxt: UA_ONE1};
      UA_ONE1:  w = '{op: OP_EMIT,  sel: SEL_ONE,  fin: 1'b1, nxt: UA_WAIT};
      UA_FOUR:  w = '{op: OP_EMIT,  sel: SEL_ONE,  fin: 1'b0, nxt: UA_FOUR2};
      UA_FOUR2: w = '{op: OP_EMIT,  sel: SEL_FIVE, fin: 1'b1, nxt: UA_WAIT};
      UA_FIVE:  w = '{op: OP_EMIT,  sel: SEL_FIVE, fin: 1'b1, nxt: UA_WAIT};
      UA_SIX:   w = '{op: OP_EMIT,  sel: SEL_FIVE, fin: 1'b0, nxt: UA_ONE1};
      UA_SEVEN: w = '{op: OP_EMIT,  sel: SEL_FIVE, fin: 1'b0, nxt: UA_ONE2};
      UA_EIGHT: w = '{op: OP_EMIT,  sel: SEL_FIVE, fin: 1'b0, nxt: UA_ONE3};
      UA_NINE:  w = '{op: OP_EMIT,  sel: SEL_ONE,  fin: 1'b0, nxt: UA_NINE2};
      UA_NINE2: w = '{op: OP_EMIT,  sel: SEL_TEN,  fin: 1'b1, nxt: UA_WAIT};
      default:  w = '{op: OP_WAIT,  sel: SEL_ONE,  fin: 1'b0, nxt: UA_SPLIT};
    endcase
    return w;
  endfunction

  // Entry point of the routine for a nonzero digit
  function automatic logic [UaddrW-1:0] dispatch(input logic [3:0] digit);
    logic [UaddrW-1:0] a;
    case (digit)
      4'd1:    a = UA_ONE1;
      4'd2:    a = UA_ONE2;
      4'd3:    a = UA_ONE3;
      4'd4:    a = UA_FOUR;
      4'd5:    a = UA_FIVE;
      4'd6:    a = UA_SIX;
      4'd7:    a = UA_SEVEN;
      4'd8:    a = UA_EIGHT;
      4'd9:    a = UA_NINE;
      default: a = UA_WAIT;
    endcase
    return a;
  endfunction

  // Weight of one unit of a place
  function automatic logic [ScaleW-1:0] place_scale(input logic [1:0] place);
    logic [ScaleW-1:0] s;
    case (place)
      PLACE_THOUS:    s = 14'd1000;
      PLACE_HUNDREDS: s = 14'd100;
      PLACE_TENS:     s = 14'd10;
      default:        s = 14'd1;
    endcase
    return s;
  endfunction

  // Letter for a place and selector
  function automatic logic [SymbolW-1:0] sym_code(input logic [1:0] place,
                                                  input irn_sel_t sel);
    logic [SymbolW-1:0] c;
    c = CH_M;
    case (place)
      PLACE_UNITS: begin
        case (sel)
          SEL_ONE:  c = CH_I;
          SEL_FIVE: c = CH_V;
          default:  c = CH_X;
        endcase
      end
      PLACE_TENS: begin
        case (sel)
          SEL_ONE:  c = CH_X;
          SEL_FIVE: c = CH_L;
          default:  c = CH_C;
        endcase
      end
      PLACE_HUNDREDS: begin
        case (sel)
          SEL_ONE:  c = CH_C;
          SEL_FIVE: c = CH_D;
          default:  c = CH_M;
        endcase
      end
      default: c = CH_M;
    endcase
    return c;
  endfunction

  // Sequencer to datapath controls
  typedef struct packed {
    logic     load;        // take a new value
    logic     split;       // extract the digit of the current place
    logic     step_place;  // move to the next lower place
    irn_sel_t sel;
  } irn_ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic [3:0] digit;       // digit of the current place
    logic       split_zero;  // nothing left below the place being split
    logic       rem_zero;    // nothing left below the current place
  } irn_stat_t;

endpackage

[hw/rtl/irn_dpath.sv]
`timescale 1ns / 1ps

module irn_dpath (
  input  logic                   clk,
  input  irn_pkg::irn_ctrl_t     ctrl,
  input  logic [11:0]            in_value,
  output irn_pkg::irn_stat_t     stat,
  output logic [6:0]             symbol
);
  import irn_pkg::*;

  logic [ValueW-1:0] rem_r;
  logic [ValueW-1:0] rem_nxt;
  logic [1:0]        place_r;
  logic [1:0]        place_nxt;
  logic [ScaleW-1:0] rem_ext;
  logic [ScaleW-1:0] scale;
  logic [3:0]        digit;
  logic [ValueW-1:0] rem_left;
  logic [ValueW-1:0] value_sat;

  // Compare the remainder against each multiple of the place weight
  always_comb begin
    rem_ext = {{(ScaleW-ValueW){1'b0}}, rem_r};
    scale   = place_scale(place_r);
    digit   = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_ext >= ScaleW'(k) * scale) begin
        digit = 4'(k);
      end
    end
    rem_left = ValueW'(rem_ext - {{(ScaleW-4){1'b0}}, digit} * scale);
  end

  // Saturate the incoming value
  assign value_sat = (in_value > VALUE_MAX) ? VALUE_MAX : in_value;

  // Select next remainder and place
  always_comb begin
    rem_nxt   = rem_r;
    place_nxt = place_r;
    if (ctrl.load) begin
      rem_nxt   = value_sat;
      place_nxt = PLACE_THOUS;
    end else begin
      if (ctrl.split) begin
        rem_nxt = rem_left;
      end
      if (ctrl.step_place) begin
        place_nxt = place_r - 2'd1;
      end
    end
  end

  // Hold remainder and place
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    place_r <= place_nxt;
  end

  assign stat.digit      = digit;
  assign stat.split_zero = (rem_left == '0);
  assign stat.rem_zero   = (rem_r == '0);
  assign symbol          = sym_code(place_r, ctrl.sel);

endmodule

[hw/rtl/irn_seq.sv]
`timescale 1ns / 1ps

module irn_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [6:0]             out_symbol,
  output logic                   out_last,
  input  irn_pkg::irn_stat_t     stat,
  input  logic [6:0]             symbol,
  output irn_pkg::irn_ctrl_t     ctrl
);
  import irn_pkg::*;

  logic [UaddrW-1:0]  upc_r;
  logic [UaddrW-1:0]  upc_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [SymbolW-1:0] out_symbol_r;
  logic [SymbolW-1:0] out_symbol_nxt;
  logic               out_last_r;
  logic               out_last_nxt;
  irn_uword_t         word;
  logic               emit_ok;

  assign word    = ucode(upc_r);
  assign emit_ok = !out_valid_r || out_tready;

  // Decode the control word and pick the next step
  always_comb begin
    upc_nxt         = upc_r;
    ctrl.load       = 1'b0;
    ctrl.split      = 1'b0;
    ctrl.step_place = 1'b0;
    ctrl.sel        = word.sel;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_symbol_nxt  = out_symbol_r;
    out_last_nxt    = out_last_r;
    case (word.op)
      OP_WAIT: begin
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          upc_nxt   = word.nxt;
        end
      end
      OP_SPLIT: begin
        ctrl.split = 1'b1;
        if (stat.digit != 4'd0) begin
          upc_nxt = dispatch(stat.digit);
        end else if (stat.split_zero) begin
          upc_nxt = UA_WAIT;
        end else begin
          ctrl.step_place = 1'b1;
          upc_nxt         = UA_SPLIT;
        end
      end
      OP_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = symbol;
          out_last_nxt   = word.fin && stat.rem_zero;
          if (!word.fin) begin
            upc_nxt = word.nxt;
          end else if (stat.rem_zero) begin
            upc_nxt = UA_WAIT;
          end else begin
            ctrl.step_place = 1'b1;
            upc_nxt         = UA_SPLIT;
          end
        end
      end
      default: begin
        upc_nxt = UA_WAIT;
      end
    endcase
  end

  // Hold step counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UA_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_tready  = (word.op == OP_WAIT);
  assign out_tvalid = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

[hw/rtl/integer_to_roman_numeral.sv]
`timescale 1ns / 1ps

// Converts an unsigned value (0 to 3999; larger values are taken as 3999) into
// its Roman numeral and streams it out one ASCII letter per request, most
// significant first, with tlast on the final letter; zero produces nothing.
// A small microprogram walks the decimal places from thousands down: it
// accepts the value, splits off the digit of each place (stopping once
// nothing nonzero is left) and emits the letters of each digit. 3888 gives
// the longest numeral, 15 letters; out_tready can stall any letter. The
// next value is taken as soon as the sequencer is back at its wait step,
// even if the final letter still waits.
module integer_to_roman_numeral (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] value, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] symbol, [7] zero
  output logic        out_tlast
);
  import irn_pkg::*;

  irn_ctrl_t          ctrl;
  irn_stat_t          stat;
  logic [SymbolW-1:0] symbol;
  logic [SymbolW-1:0] out_symbol;

  irn_dpath u_dpath (
    .clk      (clk),
    .ctrl     (ctrl),
    .in_value (in_tdata[ValueW-1:0]),
    .stat     (stat),
    .symbol   (symbol)
  );

  irn_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_symbol (out_symbol),
    .out_last   (out_tlast),
    .stat       (stat),
    .symbol     (symbol),
    .ctrl       (ctrl)
  );

  assign out_tdata = {1'b0, out_symbol};

endmodule

[hw/rtl/irn_checker.sv]
`timescale 1ns / 1ps

module irn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);
  import irn_pkg::*;

  // A stalled letter stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A stalled letter keeps its data and last flag
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out_tdata or out_tlast changed while stalled");

  // Only numeral letters leave the block
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] == CH_C || out_tdata[6:0] == CH_D ||
                    out_tdata[6:0] == CH_I || out_tdata[6:0] == CH_L ||
                    out_tdata[6:0] == CH_M || out_tdata[6:0] == CH_V ||
                    out_tdata[6:0] == CH_X))
    else $error("out_tdata is not a numeral letter");

  // Busy splitting digits in the cycle after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after a request");

  // Output channel is empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind integer_to_roman_numeral irn_checker u_irn_checker (.*);

[tb/integer_to_roman_numeral_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the Roman numeral converter, predicts the letters
// of every accepted value and checks each output request against them in order.
module integer_to_roman_numeral_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] value, [15:12] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [6:0] symbol, [7] zero
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);
  import irn_pkg::*;

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last;
  } letter_t;

  // Letters still owed by the block, oldest first
  letter_t letter_q[$];
  letter_t want;
  int      errors = 0;

  function automatic void push_letter(input logic [SymbolW-1:0] sym);
    letter_t item;
    item.symbol = sym;
    item.last   = 1'b0;
    letter_q.insert(letter_q.size(), item);
  endfunction

  // Append the numeral of one value; values past the top are clamped to 3999
  function automatic void predict_numeral(input logic [ValueW-1:0] raw);
    int                 v;
    int                 d;
    int                 div;
    int                 start;
    logic [SymbolW-1:0] one;
    logic [SymbolW-1:0] five;
    logic [SymbolW-1:0] ten;
    v = (raw > VALUE_MAX) ? int'(VALUE_MAX) : int'(raw);
    start = letter_q.size();
    repeat (v / 1000) push_letter(CH_M);
    for (int place = 2; place >= 0; place--) begin
      case (place)
        2: begin
          one = CH_C; five = CH_D; ten = CH_M; div = 100;
        end
        1: begin
          one = CH_X; five = CH_L; ten = CH_C; div = 10;
        end
        default: begin
          one = CH_I; five = CH_V; ten = CH_X; div = 1;
        end
      endcase
      d = (v / div) % 10;
      if (d == 9) begin
        push_letter(one);
        push_letter(ten);
      end else if (d == 4) begin
        push_letter(one);
        push_letter(five);
      end else begin
        if (d >= 5) begin
          push_letter(five);
          d -= 5;
        end
        repeat (d) push_letter(one);
      end
    end
    // Flag the final letter; zero leaves nothing to flag
    if (letter_q.size() > start) letter_q[letter_q.size()-1].last = 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    if (errors < 10) $display("[%0t] %s", $realtime, msg);
    errors++;
  endtask

  // Check output requests before queuing new input so a stray letter never
  // matches an expectation raised at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (letter_q.size() == 0) begin
          note_failure($sformatf("unexpected letter %0d last %0b",
                                 out_tdata, out_tlast));
        end else begin
          want = letter_q.pop_front();
          if (out_tdata !== {1'b0, want.symbol} || out_tlast !== want.last)
            note_failure($sformatf("letter mismatch: expected %0d last %0b, got %0d last %0b",
                                   want.symbol, want.last, out_tdata, out_tlast));
        end
      end
      if (in_tvalid && in_tready) predict_numeral(in_tdata[ValueW-1:0]);
    end
    pending    <= letter_q.size();
    fail_count <= errors;
  end

endmodule

[tb/integer_to_roman_numeral_tb.sv]
`timescale 1ns / 1ps

module integer_to_roman_numeral_tb;
  import irn_pkg::*;

  localparam int RandomItems = 450;
  localparam int MaxGap      = 12;
  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  logic        in_burst = 1'b0;
  logic        out_burst = 1'b0;

  integer_to_roman_numeral dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  integer_to_roman_numeral_checker numeral_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort when neither stream moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stall the output at random, with stretches of steady ready
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken % 24 == 0) out_burst = ($urandom_range(0, 3) == 0);
      stall = out_burst ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Offer one value after a random gap and hold it until the request is taken
  task automatic send_value(input logic [ValueW-1:0] v);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW-ValueW){1'b0}}, v};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [ValueW-1:0] directed[$];
    logic [ValueW-1:0] v;
    int                pick;
    // Zero, a sample of digits in each place, the longest numeral, the top of
    // range and saturated values
    directed = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd14, 12'd40,
                 12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900,
                 12'd999, 12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd4000,
                 12'd4095, 12'd0, 12'd2730};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 32 == 0) in_burst = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0)      v = '0;
      else if (pick <= 2) v = ValueW'($urandom_range(4000, 4095));
      else if (pick <= 5) v = ValueW'($urandom_range(1, 99));
      else                v = ValueW'($urandom_range(1, 3999));
      send_value(v);
    end
    in_tvalid <= 1'b0;

    // Let the checker see the last request, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[integer_to_roman_numeral.f]
hw/rtl/irn_pkg.sv
hw/rtl/irn_dpath.sv
hw/rtl/irn_seq.sv
hw/rtl/integer_to_roman_numeral.sv
hw/rtl/irn_checker.sv
tb/integer_to_roman_numeral_checker.sv
tb/integer_to_roman_numeral_tb.sv
